>>> src/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// shared types, character codes and defaults of the postfix stack evaluator
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned DATA_W          = 32;
	localparam int unsigned DIV_STEPS       = 32;

	// expression characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_POP_L,
		ST_LOAD,
		ST_EXEC,
		ST_FINISH,
		ST_EMIT
	} pse_state_t;

	typedef enum logic [1:0] {
		ALU_IDLE,
		ALU_ITER,
		ALU_DIV
	} pse_alu_mode_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic push_digit;
		logic pop;
		logic capture_rhs;
		logic alu_load;
		logic alu_step;
		logic push_result;
		logic emit;
	} pse_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic last;
		logic alu_done;
	} pse_status_t;

endpackage

>>> src/pse_if.sv
// ----------------------------------------------------------------------------
// pse_if
// valid/ready channels of the postfix stack evaluator
// ----------------------------------------------------------------------------
interface pse_expr_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

interface pse_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               divide_error;
	logic               stack_overflow;
	logic               stack_underflow;

	modport source (output valid, output result_value, output divide_error,
		output stack_overflow, output stack_underflow, input ready);
	modport sink (input valid, input result_value, input divide_error,
		input stack_overflow, input stack_underflow, output ready);
endinterface

>>> src/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pse_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath
// stack, sticky flags, iterative alu and result register
// ----------------------------------------------------------------------------
module pse_datapath #(
	parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pse_pkg::pse_cmd_t   cmd,
	output pse_pkg::pse_status_t status,
	input  logic [7:0]          in_character,
	input  logic                in_last,
	output logic signed [31:0]  result_value,
	output logic                divide_error,
	output logic                stack_overflow,
	output logic                stack_underflow
);
	import pse_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic [7:0]        char_q;
	logic              last_q;
	logic [CW-1:0]     count_q;
	logic              pop_ok_q;
	logic              div_err_q;
	logic              ovf_q;
	logic              udf_q;
	logic [DATA_W-1:0] rhs_q;

	logic              empty;
	logic              full;
	logic              push_req;
	logic              push_ok;
	logic              pop_ok;
	logic [DATA_W-1:0] push_data;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] popped;

	// alu
	pse_alu_mode_t     mode_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] sq_q;
	logic [DATA_W-1:0] ex_q;
	logic [DATA_W-1:0] quot_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic              neg_q;
	logic [5:0]        cnt_q;

	logic [DATA_W-1:0] mul_acc;
	logic [DATA_W-1:0] mul_sq;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   rem_diff;
	logic              rem_ge;
	logic [DATA_W-1:0] lhs_abs;
	logic [DATA_W-1:0] rhs_abs;
	logic [DATA_W-1:0] pow_neg;
	logic              load_div_err;
	logic              alu_done;
	logic [DATA_W-1:0] alu_result;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign push_req  = cmd.push_digit | cmd.push_result;
	assign push_ok   = push_req & ~full;
	assign pop_ok    = cmd.pop & ~empty;
	assign push_data = cmd.push_digit ? DATA_W'(char_q - CH_ZERO) : alu_result;
	// value of the last pop, 0 when it found the stack empty
	assign popped    = pop_ok_q ? ram_rdata : '0;

	pse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (push_ok),
		.waddr(count_q[AW-1:0]),
		.wdata(push_data),
		.re   (pop_ok),
		.raddr(AW'(count_q - CW'(1))),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			char_q <= in_character;
			last_q <= in_last;
		end
		if (cmd.capture_rhs) begin
			rhs_q <= popped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pop_ok_q  <= 1'b0;
			div_err_q <= 1'b0;
			ovf_q     <= 1'b0;
			udf_q     <= 1'b0;
		end else begin
			if (cmd.pop) begin
				pop_ok_q <= ~empty;
			end
			if (cmd.emit) begin
				count_q   <= '0;
				div_err_q <= 1'b0;
				ovf_q     <= 1'b0;
				udf_q     <= 1'b0;
			end else begin
				if (push_ok) begin
					count_q <= count_q + CW'(1);
				end else if (pop_ok) begin
					count_q <= count_q - CW'(1);
				end
				if (push_req && full) begin
					ovf_q <= 1'b1;
				end
				if (cmd.pop && empty) begin
					udf_q <= 1'b1;
				end
				if (load_div_err) begin
					div_err_q <= 1'b1;
				end
			end
		end
	end

	// alu operand preparation
	assign lhs_abs = popped[DATA_W-1] ? (~popped + DATA_W'(1)) : popped;
	assign rhs_abs = rhs_q[DATA_W-1] ? (~rhs_q + DATA_W'(1)) : rhs_q;

	// power with a negative exponent
	always_comb begin
		if (popped == DATA_W'(1)) begin
			pow_neg = DATA_W'(1);
		end else if (popped == '1) begin
			pow_neg = rhs_q[0] ? '1 : DATA_W'(1);
		end else begin
			pow_neg = '0;
		end
	end

	assign load_div_err = cmd.alu_load &
		(((char_q == CH_SLASH) && (rhs_q == '0)) ||
		 ((char_q == CH_CARET) && rhs_q[DATA_W-1] && (popped == '0)));

	assign mul_acc  = acc_q * sq_q;
	assign mul_sq   = sq_q * sq_q;
	assign rem_sh   = {rem_q, quot_q[DATA_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign rem_ge   = ~rem_diff[DATA_W];

	always_ff @(posedge clk) begin
		if (cmd.alu_load) begin
			unique case (char_q)
				CH_PLUS: begin
					acc_q <= popped + rhs_q;
					ex_q  <= '0;
				end
				CH_MINUS: begin
					acc_q <= popped - rhs_q;
					ex_q  <= '0;
				end
				CH_STAR: begin
					acc_q <= popped;
					sq_q  <= rhs_q;
					ex_q  <= DATA_W'(1);
				end
				CH_SLASH: begin
					acc_q  <= '0;
					ex_q   <= '0;
					quot_q <= lhs_abs;
					den_q  <= rhs_abs;
					rem_q  <= '0;
					neg_q  <= popped[DATA_W-1] ^ rhs_q[DATA_W-1];
				end
				default: begin
					if (rhs_q[DATA_W-1]) begin
						acc_q <= pow_neg;
						ex_q  <= '0;
					end else begin
						acc_q <= DATA_W'(1);
						sq_q  <= popped;
						ex_q  <= rhs_q;
					end
				end
			endcase
		end else if (cmd.alu_step) begin
			if (mode_q == ALU_DIV) begin
				rem_q  <= rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
				quot_q <= {quot_q[DATA_W-2:0], rem_ge};
			end else begin
				// square and multiply, one exponent bit a step
				if (ex_q[0]) begin
					acc_q <= mul_acc;
				end
				sq_q <= mul_sq;
				ex_q <= ex_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ALU_IDLE;
			cnt_q  <= '0;
		end else if (cmd.alu_load) begin
			if ((char_q == CH_SLASH) && (rhs_q != '0)) begin
				mode_q <= ALU_DIV;
				cnt_q  <= 6'(DIV_STEPS);
			end else begin
				mode_q <= ALU_ITER;
				cnt_q  <= '0;
			end
		end else if (cmd.alu_step && (mode_q == ALU_DIV)) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_comb begin
		unique case (mode_q)
			ALU_ITER: alu_done = (ex_q == '0);
			ALU_DIV:  alu_done = (cnt_q == '0);
			default:  alu_done = 1'b1;
		endcase
	end

	assign alu_result = (mode_q == ALU_DIV) ?
		(neg_q ? (~quot_q + DATA_W'(1)) : quot_q) : acc_q;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_value    <= popped;
			divide_error    <= div_err_q;
			stack_overflow  <= ovf_q;
			stack_underflow <= udf_q;
		end
	end

	assign status.is_digit = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
	assign status.is_op    = (char_q == CH_PLUS) || (char_q == CH_MINUS) ||
		(char_q == CH_STAR) || (char_q == CH_SLASH) || (char_q == CH_CARET);
	assign status.last     = last_q;
	assign status.alu_done = alu_done;

endmodule

>>> src/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// sequencer of the postfix stack evaluator and result word handshake
// ----------------------------------------------------------------------------
module pse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  pse_pkg::pse_status_t status,
	output pse_pkg::pse_cmd_t    cmd
);
	import pse_pkg::*;

	pse_state_t state_q;
	pse_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = ~out_valid_q | out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (status.is_digit) begin
					cmd.push_digit = 1'b1;
					state_d        = ST_FINISH;
				end else if (status.is_op) begin
					cmd.pop = 1'b1;
					state_d = ST_POP_L;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_POP_L: begin
				cmd.capture_rhs = 1'b1;
				cmd.pop         = 1'b1;
				state_d         = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.alu_load = 1'b1;
				state_d      = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.alu_done) begin
					cmd.push_result = 1'b1;
					state_d         = ST_FINISH;
				end else begin
					cmd.alu_step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (status.last) begin
					cmd.pop = 1'b1;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// postfix expression evaluator over a bounded stack of 32-bit signed values
// ----------------------------------------------------------------------------
// usage
// - expr carries one expression character a word, with last marking the end
//   of the expression; digits push, + - * / ^ pop two operands and push the
//   wrapping 32-bit result, anything else is ignored
// - result carries one word per expression: the popped top of stack and the
//   sticky divide, overflow and underflow flags; the stack and flags are then
//   cleared for the next expression
// - each word is accepted, then dispatched; an operator pops both operands,
//   loads the alu and steps it until done before pushing the result; the
//   32-step shift-subtract divider and the square-and-multiply loop set the
//   worst case; with last, the popped top is then handed to the output
//   register, later while that register is still stalled
// - one word is in work at a time; expr.ready is high only while the
//   sequencer is idle
// - a finished result waits in the output register while the next
//   expression is taken; if result stays stalled, the following result
//   holds the sequencer until the register frees up
// - reset empties the stack, clears the flags and drops any pending result;
//   stack storage is not cleared and needs no sweep
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
	parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pse_expr_if.sink     expr,
	pse_result_if.source result
);
	import pse_pkg::*;

	// command and status between sequencer and datapath
	pse_cmd_t    cmd;
	pse_status_t status;

	pse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (expr.valid),
		.in_ready (expr.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// stack in ram, sticky flags, iterative alu and output payload
	pse_datapath #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_character   (expr.character),
		.in_last        (expr.last),
		.result_value   (result.result_value),
		.divide_error   (result.divide_error),
		.stack_overflow (result.stack_overflow),
		.stack_underflow(result.stack_underflow)
	);

endmodule

>>> src/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// port level checks of the postfix stack evaluator, bound to the top level
// ----------------------------------------------------------------------------
module pse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [34:0] out_payload
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result word changed while stalled");

	// one word in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("expr ready right after accepting a word");

	// a result word appears as the sequencer returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result word raised while busy");

	// a word without last produces no result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_last |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result word without last");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (expr.valid),
	.in_ready   (expr.ready),
	.in_last    (expr.last),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_payload({result.result_value, result.divide_error,
		result.stack_overflow, result.stack_underflow})
);

>>> bench/tb_postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator
// self-checking bench for the postfix stack evaluator: expression words go in
// through a driver with random gaps, results are checked against an in-bench
// calculator model of the value stack and its sticky flags
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_postfix_stack_evaluator;
	import pse_pkg::*;

	localparam int unsigned DEPTH       = STACK_DEPTH_DEF;
	localparam int          WORD_TARGET = 1050;
	localparam int          CALM_TAIL   = 120;   // words left when idling stops
	localparam int          DRAIN_WAIT  = 60;    // longer than the slowest word and its hand-off
	localparam int          MAX_REPORTS = 10;

	// one expression character waiting to be driven
	typedef struct {
		logic [7:0] ch;
		bit         last;
		bit         hold;   // wait until every result is back before sending
	} expr_word_t;

	// what the block must return for one expression
	typedef struct {
		logic signed [31:0] value;
		bit                 div_err;
		bit                 ovf;
		bit                 unf;
	} eval_result_t;

	logic clk = 1'b0;
	logic arst_n;

	pse_expr_if   expr_ch ();
	pse_result_if result_ch ();

	postfix_stack_evaluator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.expr   (expr_ch),
		.result (result_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// calculator model: value stack, depth and sticky flags
	// ------------------------------------------------------------------------
	logic [31:0] calc_stack [DEPTH];
	int unsigned calc_depth;
	bit          calc_div_err;
	bit          calc_ovf;
	bit          calc_unf;

	expr_word_t   pending_words [$];
	eval_result_t predicted_results [$];

	int words_taken;
	int exprs_predicted;
	int results_seen;
	int error_count;
	int div_err_exprs;
	int ovf_exprs;
	int unf_exprs;

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_operator(logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
			c == CH_CARET;
	endfunction

	function automatic void calc_push(logic [31:0] v);
		if (calc_depth >= DEPTH) begin
			// full stack drops the value
			calc_ovf = 1'b1;
			return;
		end
		calc_stack[calc_depth] = v;
		calc_depth++;
	endfunction

	function automatic logic [31:0] calc_pop();
		if (calc_depth == 0) begin
			// empty stack reads as zero
			calc_unf = 1'b1;
			return '0;
		end
		calc_depth--;
		return calc_stack[calc_depth];
	endfunction

	function automatic logic [31:0] raise_power(logic [31:0] base, logic [31:0] expo);
		logic [31:0] acc;
		logic [31:0] sq;
		acc = 32'd1;
		sq  = base;
		if (expo[31]) begin
			// negative exponent: only unit bases survive, zero base is an error
			if (base == 32'd1)
				return 32'd1;
			if (base == '1)
				return expo[0] ? '1 : 32'd1;
			if (base == '0)
				calc_div_err = 1'b1;
			return '0;
		end
		while (expo != 0) begin
			if (expo[0])
				acc = acc * sq;
			sq   = sq * sq;
			expo = expo >> 1;
		end
		return acc;
	endfunction

	function automatic logic [31:0] calc_divide(logic [31:0] lhs, logic [31:0] rhs);
		longint num;
		longint den;
		longint quo;
		num = $signed(lhs);
		den = $signed(rhs);
		if (den == 0) begin
			calc_div_err = 1'b1;
			return '0;
		end
		// 64-bit quotient, so min / -1 wraps back to min in the low half
		quo = num / den;
		return quo[31:0];
	endfunction

	function automatic logic [31:0] apply_operator(logic [7:0] op, logic [31:0] lhs,
		logic [31:0] rhs);
		case (op)
			CH_PLUS:  return lhs + rhs;
			CH_MINUS: return lhs - rhs;
			CH_STAR:  return lhs * rhs;
			CH_SLASH: return calc_divide(lhs, rhs);
			default:  return raise_power(lhs, rhs);
		endcase
	endfunction

	// advance the model by one accepted word; an end word predicts a result
	function automatic void evaluate_word(logic [7:0] c, logic last);
		logic [31:0]  lhs;
		logic [31:0]  rhs;
		eval_result_t res;
		if (is_digit(c)) begin
			calc_push(32'(c - CH_ZERO));
		end else if (is_operator(c)) begin
			rhs = calc_pop();
			lhs = calc_pop();
			calc_push(apply_operator(c, lhs, rhs));
		end
		if (!last)
			return;
		res.value   = calc_pop();
		res.div_err = calc_div_err;
		res.ovf     = calc_ovf;
		res.unf     = calc_unf;
		predicted_results.push_back(res);
		exprs_predicted++;
		div_err_exprs += res.div_err;
		ovf_exprs     += res.ovf;
		unf_exprs     += res.unf;
		// stack and flags start over for the next expression
		calc_depth   = 0;
		calc_div_err = 1'b0;
		calc_ovf     = 1'b0;
		calc_unf     = 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------------
	function automatic void add_word(logic [7:0] c, bit last, bit hold = 1'b0);
		expr_word_t w;
		w.ch   = c;
		w.last = last;
		w.hold = hold;
		pending_words.push_back(w);
	endfunction

	// whole expression, end marker on its final character
	function automatic void add_text(string s, bit hold = 1'b0);
		for (int i = 0; i < s.len(); i++)
			add_word(s[i], i == s.len() - 1, hold && i == 0);
	endfunction

	function automatic logic [7:0] random_operator();
		case ($urandom_range(0, 4))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			3:       return CH_SLASH;
			default: return CH_CARET;
		endcase
	endfunction

	function automatic logic [7:0] random_digit();
		// lean on nine so products and powers wrap
		if ($urandom_range(0, 3) == 0)
			return CH_NINE;
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_filler();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (is_digit(c) || is_operator(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic void flush_body(ref logic [7:0] body [$]);
		for (int i = 0; i < body.size(); i++)
			add_word(body[i], i == body.size() - 1);
	endfunction

	// well-formed expression with random digits, operators and stray filler
	function automatic void add_random_expression();
		logic [7:0] body [$];
		int         depth;
		int         len;
		depth = 0;
		len   = $urandom_range(1, 14);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				body.push_back(random_filler());
			if (depth >= 2 && $urandom_range(0, 2) != 0) begin
				body.push_back(random_operator());
				depth--;
			end else begin
				body.push_back(random_digit());
				depth++;
			end
		end
		while (depth > 1) begin
			body.push_back(random_operator());
			depth--;
		end
		if ($urandom_range(0, 9) == 0)
			body.push_back(random_filler());
		flush_body(body);
	endfunction

	// power with a negative exponent over the interesting bases
	function automatic void add_negative_power();
		logic [7:0] body [$];
		case ($urandom_range(0, 4))
			0: body.push_back(CH_ZERO + 8'd1);
			1: begin body.push_back(CH_ZERO); body.push_back(CH_ZERO + 8'd1);
				body.push_back(CH_MINUS); end
			2: body.push_back(CH_ZERO);
			3: body.push_back(CH_ZERO + 8'($urandom_range(2, 9)));
			default: begin body.push_back(CH_ZERO); body.push_back(random_digit());
				body.push_back(CH_MINUS); end
		endcase
		body.push_back(CH_ZERO);
		body.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
		body.push_back(CH_MINUS);
		body.push_back(CH_CARET);
		flush_body(body);
	endfunction

	// more pushes than the stack holds, then some operators
	function automatic void add_overflow();
		logic [7:0] body [$];
		int         n;
		n = $urandom_range(DEPTH + 1, DEPTH + 4);
		for (int i = 0; i < n; i++)
			body.push_back(random_digit());
		for (int i = $urandom_range(0, DEPTH); i > 0; i--)
			body.push_back(random_operator());
		flush_body(body);
	endfunction

	// operators short of operands
	function automatic void add_starved();
		logic [7:0] body [$];
		for (int i = $urandom_range(0, 2); i > 0; i--)
			body.push_back(random_digit());
		for (int i = $urandom_range(1, 4); i > 0; i--)
			body.push_back(random_operator());
		flush_body(body);
	endfunction

	// raw bytes of any value; sometimes with no end mark, so it runs into the next
	function automatic void add_noise();
		int n;
		bit closed;
		n      = $urandom_range(1, 6);
		closed = $urandom_range(0, 3) != 0;
		for (int i = 0; i < n; i++)
			add_word(8'($urandom_range(0, 255)), closed && i == n - 1);
	endfunction

	function automatic void build_directed();
		add_word(8'hFF, 1'b1);            // ignored top byte, final pop on empty
		add_text("9*");                   // multiply with a missing operand
		add_text("73-");
		add_text("07-2/");                // -7 / 2 truncates toward zero
		add_text("50/");                  // divide by zero
		add_text("00^");                  // zero to the zeroth power
		add_text("001-^");                // zero to a negative power
		add_word(CH_ZERO + 8'd8, 1'b0);
		add_word(8'h00, 1'b1);            // end mark on an ignored zero byte
		add_text("12+");
	endfunction

	// ------------------------------------------------------------------------
	// idling control
	// ------------------------------------------------------------------------
	// every third stretch of 150 words runs without gaps; the tail never idles
	function automatic bit idling_on();
		return pending_words.size() > CALM_TAIL && (words_taken / 150) % 3 != 2;
	endfunction

	// ------------------------------------------------------------------------
	// driver: one word from the pending queue at a time
	// ------------------------------------------------------------------------
	int gap_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expr_ch.valid     <= 1'b0;
			expr_ch.character <= '0;
			expr_ch.last      <= 1'b0;
			gap_cycles = 0;
		end else begin
			if (expr_ch.valid && expr_ch.ready) begin
				evaluate_word(expr_ch.character, expr_ch.last);
				words_taken++;
			end
			if (!expr_ch.valid || expr_ch.ready) begin
				if (gap_cycles != 0) begin
					gap_cycles--;
					expr_ch.valid <= 1'b0;
				end else if (pending_words.size() == 0 ||
					(pending_words[0].hold && predicted_results.size() != 0)) begin
					// nothing left, or holding until the block has drained
					expr_ch.valid <= 1'b0;
				end else if (idling_on() && $urandom_range(0, 99) < 20) begin
					// idle burst of random length, starting now
					gap_cycles = $urandom_range(0, 3);
					expr_ch.valid <= 1'b0;
				end else begin
					expr_ch.valid     <= 1'b1;
					expr_ch.character <= pending_words[0].ch;
					expr_ch.last      <= pending_words[0].last;
					void'(pending_words.pop_front());
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: random back-pressure and result checking
	// ------------------------------------------------------------------------
	int stall_cycles;

	task automatic check_result();
		eval_result_t want;
		if (predicted_results.size() == 0) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%t: result %0d with no expression pending", $realtime,
					result_ch.result_value);
			return;
		end
		want = predicted_results.pop_front();
		results_seen++;
		if (result_ch.result_value !== want.value ||
			result_ch.divide_error !== want.div_err ||
			result_ch.stack_overflow !== want.ovf ||
			result_ch.stack_underflow !== want.unf) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%t: expression %0d: expected %0d div %0b ovf %0b unf %0b,",
					$realtime, results_seen, want.value, want.div_err, want.ovf, want.unf,
					" got %0d div %0b ovf %0b unf %0b",
					result_ch.result_value, result_ch.divide_error,
					result_ch.stack_overflow, result_ch.stack_underflow);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_cycles = 0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				check_result();
			if (stall_cycles != 0) begin
				stall_cycles--;
				result_ch.ready <= 1'b0;
			end else if (idling_on() && $urandom_range(0, 99) < 20) begin
				stall_cycles = $urandom_range(0, 3);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// run control
	// ------------------------------------------------------------------------
	initial begin
		int pick;
		arst_n            = 1'b0;
		calc_depth        = 0;
		calc_div_err      = 1'b0;
		calc_ovf          = 1'b0;
		calc_unf          = 1'b0;

		build_directed();
		// the min / -1 expression waits for the directed ones to drain
		add_text("02-48*1-^01-/", 1'b1);  // min / -1
		while (pending_words.size() < WORD_TARGET) begin
			// one more full drain halfway through
			if (pending_words.size() >= WORD_TARGET / 2 &&
				pending_words.size() < WORD_TARGET / 2 + 20)
				add_text("98-", 1'b1);
			pick = $urandom_range(0, 99);
			if (pick < 55)
				add_random_expression();
			else if (pick < 66)
				add_negative_power();
			else if (pick < 70)
				add_text($urandom_range(0, 1) ? "02-48*1-^01-/" : "02-48*1-^");
			else if (pick < 77)
				add_overflow();
			else if (pick < 87)
				add_starved();
			else
				add_noise();
		end
		// close any noise left open so the last expression produces a result
		add_text("5");

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || expr_ch.valid)
			@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d expression words forming %0d expressions, %0d results checked",
			words_taken, exprs_predicted, results_seen);
		$display("flags expected: %0d divide errors, %0d overflows, %0d underflows",
			div_err_exprs, ovf_exprs, unf_exprs);
		if (error_count == 0 && predicted_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
src/pse_pkg.sv
src/pse_if.sv
src/pse_ram.sv
src/pse_datapath.sv
src/pse_ctrl.sv
src/postfix_stack_evaluator.sv
src/pse_checker.sv
bench/tb_postfix_stack_evaluator.sv
